// File: design/lcts_pkg.sv
// Shared constants for the load cell tare and weigh sequencer.
package lcts_pkg;

  // Phase codes
  localparam logic [1:0] PH_PROBE  = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_TARE   = 2'd2;
  localparam logic [1:0] PH_WEIGH  = 2'd3;

  // Event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_NOT_FOUND   = 3'd1;
  localparam logic [2:0] EV_FOUND       = 3'd2;
  localparam logic [2:0] EV_TARE_SAMPLE = 3'd3;
  localparam logic [2:0] EV_TARE_DONE   = 3'd4;
  localparam logic [2:0] EV_WEIGHT      = 3'd5;
  localparam logic [2:0] EV_LOST        = 3'd6;

  // Input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_RETARE = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SCALE      = 3'd0;
  localparam logic [2:0] REG_ZERO_BAND  = 3'd1;
  localparam logic [2:0] REG_PROBE      = 3'd2;
  localparam logic [2:0] REG_SETTLE     = 3'd3;
  localparam logic [2:0] REG_SPACING    = 3'd4;
  localparam logic [2:0] REG_REPORT     = 3'd5;

  // Register reset values
  localparam logic [23:0] SCALE_RST     = 24'd189027;
  localparam logic [15:0] ZERO_BAND_RST = 16'd200;
  localparam logic [15:0] PROBE_RST     = 16'd2000;
  localparam logic [15:0] SETTLE_RST    = 16'd1500;
  localparam logic [15:0] SPACING_RST   = 16'd110;
  localparam logic [15:0] REPORT_RST    = 16'd500;

  // Readings averaged into one tare offset
  localparam int unsigned TARE_TOTAL = 10;

  // Field widths
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned COUNT_W  = 4;

endpackage

// File: design/load_cell_tare_weigh_sequencer_core.sv
// Load cell tare and weigh sequencer: input register, one-pass step logic, result register.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser: cmd; tdata: sensor_ready, sample_raw
//  out_    | out | out_tvalid/out_tready| tuser: event_res; tdata: phase .. connected
//  cfg_    | in  | APB psel/penable     | six registers at byte address 4*index
//
// One word per cycle sustained while out_tready holds; a word passes the input register, then
// the result register, where its result waits to be taken. Sequencer state updates as
// a word moves from the input register into the result register, so the next word sees
// it at once. rst_n is synchronous, clears the sequencer and loads the register defaults.
// A stalled result holds; the input register takes one more word, then in_tready drops.
module load_cell_tare_weigh_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [0] sensor_ready, [24:1] sample_raw, [31:25] zero
  input  logic [0:0]  in_tuser,   // [0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [1:0] phase, [2] sample_read, [34:3] weight_mg,
                                  // [38:35] tare_progress, [62:39] offset_now,
                                  // [63] tared, [64] connected, [71:65] zero
  output logic [2:0]  out_tuser,  // [2:0] event_res
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SB     = lcts_pkg::SAMPLE_W;
  localparam int unsigned SUM_W  = SB + 4;                 // up to 15 samples
  localparam int unsigned MAG_W  = SB + 3;                 // magnitude of a sum
  localparam int unsigned DIV_SH = MAG_W + $clog2(lcts_pkg::TARE_TOTAL);
  localparam logic [63:0] DIV_M  =
    ((64'd1 << DIV_SH) + 64'(lcts_pkg::TARE_TOTAL) - 64'd1) / 64'(lcts_pkg::TARE_TOTAL);
  localparam int unsigned B_W    = (SB + 6 > 26) ? SB + 6 : 26;
  localparam int unsigned P_W    = SUM_W + B_W;
  localparam int unsigned SH_W   = P_W - 16;
  localparam int unsigned CMP_W  = (SH_W > 33) ? SH_W : 33;
  localparam logic signed [CMP_W-1:0] W_MAX = CMP_W'(64'sd2147483647);
  localparam logic signed [CMP_W-1:0] W_MIN = -W_MAX - CMP_W'(64'sd1);
  localparam logic [lcts_pkg::COUNT_W-1:0] TARE_N =
    lcts_pkg::COUNT_W'(lcts_pkg::TARE_TOTAL);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [23:0] scale_r;
  logic [15:0] zero_band_r;
  logic [15:0] probe_r;
  logic [15:0] settle_r;
  logic [15:0] spacing_r;
  logic [15:0] report_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= lcts_pkg::SCALE_RST;
      zero_band_r <= lcts_pkg::ZERO_BAND_RST;
      probe_r     <= lcts_pkg::PROBE_RST;
      settle_r    <= lcts_pkg::SETTLE_RST;
      spacing_r   <= lcts_pkg::SPACING_RST;
      report_r    <= lcts_pkg::REPORT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lcts_pkg::REG_SCALE:     scale_r     <= cfg_pwdata[23:0];
        lcts_pkg::REG_ZERO_BAND: zero_band_r <= cfg_pwdata[15:0];
        lcts_pkg::REG_PROBE:     probe_r     <= cfg_pwdata[15:0];
        lcts_pkg::REG_SETTLE:    settle_r    <= cfg_pwdata[15:0];
        lcts_pkg::REG_SPACING:   spacing_r   <= cfg_pwdata[15:0];
        lcts_pkg::REG_REPORT:    report_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (cfg_idx)
      lcts_pkg::REG_SCALE:     cfg_prdata = {8'd0, scale_r};
      lcts_pkg::REG_ZERO_BAND: cfg_prdata = {16'd0, zero_band_r};
      lcts_pkg::REG_PROBE:     cfg_prdata = {16'd0, probe_r};
      lcts_pkg::REG_SETTLE:    cfg_prdata = {16'd0, settle_r};
      lcts_pkg::REG_SPACING:   cfg_prdata = {16'd0, spacing_r};
      lcts_pkg::REG_REPORT:    cfg_prdata = {16'd0, report_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and pipeline flow
  logic        in_valid_r;
  logic        in_cmd_r;
  logic        in_rdy_r;
  logic [23:0] in_sample_r;
  logic        out_valid_r;
  logic        adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r    <= in_tuser[0];
      in_rdy_r    <= in_tdata[0];
      in_sample_r <= in_tdata[24:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  logic [1:0]                   phase_r, phase_nxt;
  logic [15:0]                  elapsed_r, elapsed_nxt;
  logic signed [SUM_W-1:0]      tare_sum_r, tare_sum_nxt;
  logic [lcts_pkg::COUNT_W-1:0] tare_cnt_r, tare_cnt_nxt;
  logic signed [SB-1:0]         offset_r, offset_nxt;
  logic                         tared_r, tared_nxt;
  logic signed [31:0]           held_r, held_nxt;
  logic [2:0]                   ev;
  logic                         rd;

  // datapath signals
  logic signed [SB-1:0]    samp;
  logic [15:0]             elapsed_inc;
  logic signed [SUM_W-1:0] new_sum;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [SB:0]      diff;
  logic signed [SUM_W-1:0] mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;
  logic [SB-1:0]           quo;
  logic signed [SB-1:0]    avg;
  logic signed [SH_W-1:0]  wsh;
  logic signed [CMP_W-1:0] wext;
  logic signed [31:0]      wsat;
  logic signed [32:0]      w33;
  logic signed [32:0]      zb33;
  logic signed [31:0]      wgt;
  logic [lcts_pkg::COUNT_W-1:0] cnt_inc;

  assign samp        = $signed(in_sample_r[SB-1:0]);
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  // tare average: sum magnitude times a reciprocal, exact for every sum
  assign new_sum = tare_sum_r + SUM_W'(samp);
  assign sum_neg = new_sum[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-new_sum) : SUM_W'(new_sum);

  // weight difference against the current offset
  assign diff = (SB+1)'(samp) - (SB+1)'(offset_r);

  // one shared multiplier: reciprocal in taring, scale in weighing
  assign mul_a = (phase_r == lcts_pkg::PH_TARE) ? $signed(sum_mag) : SUM_W'(diff);
  assign mul_b = (phase_r == lcts_pkg::PH_TARE) ? $signed(B_W'(DIV_M))
                                                : $signed(B_W'(scale_r));
  assign prod  = mul_a * mul_b;

  assign quo = prod[DIV_SH +: SB];
  assign avg = sum_neg ? -$signed(quo) : $signed(quo);

  // floor shift, saturate, dead band
  assign wsh  = prod[P_W-1:16];
  assign wext = CMP_W'(wsh);
  always_comb begin
    if (wext > W_MAX) begin
      wsat = 32'sh7FFFFFFF;
    end else if (wext < W_MIN) begin
      wsat = 32'sh80000000;
    end else begin
      wsat = wext[31:0];
    end
  end
  assign w33  = 33'(wsat);
  assign zb33 = $signed({17'd0, zero_band_r});
  assign wgt  = (w33 > -zb33 && w33 < zb33) ? 32'sd0 : wsat;

  assign cnt_inc = tare_cnt_r + 4'd1;

  // step logic
  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    tare_sum_nxt = tare_sum_r;
    tare_cnt_nxt = tare_cnt_r;
    offset_nxt   = offset_r;
    tared_nxt    = tared_r;
    held_nxt     = held_r;
    ev           = lcts_pkg::EV_NONE;
    rd           = 1'b0;
    if (in_cmd_r == lcts_pkg::CMD_RETARE) begin
      tare_sum_nxt = '0;
      tare_cnt_nxt = '0;
      tared_nxt    = 1'b0;
      elapsed_nxt  = '0;
      phase_nxt    = lcts_pkg::PH_TARE;
    end else begin
      elapsed_nxt = elapsed_inc;
      unique case (phase_r)
        lcts_pkg::PH_PROBE: begin
          if (in_rdy_r) begin
            ev          = lcts_pkg::EV_FOUND;
            elapsed_nxt = '0;
            phase_nxt   = lcts_pkg::PH_SETTLE;
          end else if (elapsed_inc >= probe_r) begin
            ev          = lcts_pkg::EV_NOT_FOUND;
            elapsed_nxt = '0;
          end
        end
        lcts_pkg::PH_SETTLE: begin
          if (elapsed_inc >= settle_r) begin
            tare_sum_nxt = '0;
            tare_cnt_nxt = '0;
            elapsed_nxt  = '0;
            phase_nxt    = lcts_pkg::PH_TARE;
          end
        end
        lcts_pkg::PH_TARE: begin
          if (in_rdy_r && elapsed_inc >= spacing_r) begin
            elapsed_nxt  = '0;
            rd           = 1'b1;
            tare_sum_nxt = new_sum;
            tare_cnt_nxt = cnt_inc;
            ev           = lcts_pkg::EV_TARE_SAMPLE;
            if (cnt_inc >= TARE_N) begin
              offset_nxt = avg;
              tared_nxt  = 1'b1;
              phase_nxt  = lcts_pkg::PH_WEIGH;
              ev         = lcts_pkg::EV_TARE_DONE;
            end
          end
        end
        lcts_pkg::PH_WEIGH: begin
          if (elapsed_inc >= report_r) begin
            elapsed_nxt = '0;
            if (in_rdy_r) begin
              rd       = 1'b1;
              held_nxt = wgt;
              ev       = lcts_pkg::EV_WEIGHT;
            end else begin
              ev = lcts_pkg::EV_LOST;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lcts_pkg::PH_PROBE;
      elapsed_r  <= '0;
      tare_sum_r <= '0;
      tare_cnt_r <= '0;
      offset_r   <= '0;
      tared_r    <= 1'b0;
      held_r     <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      tare_sum_r <= tare_sum_nxt;
      tare_cnt_r <= tare_cnt_nxt;
      offset_r   <= offset_nxt;
      tared_r    <= tared_nxt;
      held_r     <= held_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  logic [1:0]                   o_phase_r;
  logic [2:0]                   o_ev_r;
  logic                         o_rd_r;
  logic signed [31:0]           o_weight_r;
  logic [lcts_pkg::COUNT_W-1:0] o_prog_r;
  logic signed [23:0]           o_offset_r;
  logic                         o_tared_r;
  logic                         o_conn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_phase_r  <= phase_nxt;
      o_ev_r     <= ev;
      o_rd_r     <= rd;
      o_weight_r <= held_nxt;
      o_prog_r   <= tare_cnt_nxt;
      o_offset_r <= 24'(offset_nxt);
      o_tared_r  <= tared_nxt;
      o_conn_r   <= (phase_nxt == lcts_pkg::PH_WEIGH);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_ev_r;
  assign out_tdata  = {7'd0, o_conn_r, o_tared_r, o_offset_r, o_prog_r,
                       o_weight_r, o_rd_r, o_phase_r};

  // ---------------------------------------------------------------------------
  // Assertions
  a_done_enters_weigh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_ev_r == lcts_pkg::EV_TARE_DONE
      |-> o_phase_r == lcts_pkg::PH_WEIGH && o_tared_r && o_prog_r == TARE_N)
    else $error("tare done without weigh phase and full count");

  a_read_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_rd_r
      |-> o_ev_r == lcts_pkg::EV_TARE_SAMPLE || o_ev_r == lcts_pkg::EV_TARE_DONE ||
          o_ev_r == lcts_pkg::EV_WEIGHT)
    else $error("sample consumed without a reading event");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tare_cnt_r <= TARE_N)
    else $error("tare count beyond sample total");

  a_found_settles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_ev_r == lcts_pkg::EV_FOUND |-> o_phase_r == lcts_pkg::PH_SETTLE)
    else $error("found event outside settle phase");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r) && $stable(tare_cnt_r) && $stable(held_r))
    else $error("sequencer state moved without an item");

endmodule

// File: dv/lcts_reading_checker.sv
`timescale 1ns / 100ps
// Checker for the load cell sequencer: tracks register writes, predicts each result word, compares.
module lcts_reading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [0] sensor_ready, [24:1] sample_raw, [31:25] zero
  input  logic [0:0]  in_tuser,   // [0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // [1:0] phase, [2] sample_read, [34:3] weight_mg,
                                  // [38:35] tare_progress, [62:39] offset_now,
                                  // [63] tared, [64] connected, [71:65] zero
  input  logic [2:0]  out_tuser,  // [2:0] event_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          error_total,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  ev;
    logic        rd;
    logic [31:0] weight;
    logic [3:0]  progress;
    logic [23:0] offset;
    logic        tared;
    logic        conn;
  } reading_t;

  // register copies
  logic [23:0] scale_q;
  logic [15:0] zband_q, probe_q, settle_q, spacing_q, report_q;

  // sequencer state copies
  logic [1:0]  phase_q;
  logic [15:0] elapsed_q;
  int          tare_sum_q;
  logic [3:0]  tare_cnt_q;
  logic [23:0] offset_q;
  logic        tared_q;
  logic [31:0] held_q;

  reading_t pending_readings[$];

  initial begin
    error_total = 0;
    pending = 0;
  end

  // weight in mg: floor of (raw - offset) * scale / 2^16, saturated, dead band applied
  function automatic logic [31:0] weigh_mg(input int smp);
    longint prod, q;
    prod = (longint'(smp) - longint'($signed(offset_q))) * longint'(scale_q);
    q = prod >>> 16;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    if (q > -longint'(zband_q) && q < longint'(zband_q)) q = 0;
    return q[31:0];
  endfunction

  // advance the sequencer by one word and build the result it causes
  function automatic reading_t step_sequencer(input logic cmd, input logic ready,
                                              input logic [23:0] raw);
    reading_t r;
    int smp;
    r.ev = lcts_pkg::EV_NONE;
    r.rd = 1'b0;
    smp = int'($signed(raw));
    if (cmd == lcts_pkg::CMD_RETARE) begin
      tare_sum_q = 0;
      tare_cnt_q = '0;
      tared_q = 1'b0;
      elapsed_q = '0;
      phase_q = lcts_pkg::PH_TARE;
    end else begin
      if (elapsed_q != 16'hFFFF) elapsed_q = elapsed_q + 16'd1;
      case (phase_q)
        lcts_pkg::PH_PROBE: begin
          if (ready) begin
            r.ev = lcts_pkg::EV_FOUND;
            elapsed_q = '0;
            phase_q = lcts_pkg::PH_SETTLE;
          end else if (elapsed_q >= probe_q) begin
            r.ev = lcts_pkg::EV_NOT_FOUND;
            elapsed_q = '0;
          end
        end
        lcts_pkg::PH_SETTLE: begin
          if (elapsed_q >= settle_q) begin
            tare_sum_q = 0;
            tare_cnt_q = '0;
            elapsed_q = '0;
            phase_q = lcts_pkg::PH_TARE;
          end
        end
        lcts_pkg::PH_TARE: begin
          if (ready && elapsed_q >= spacing_q) begin
            elapsed_q = '0;
            r.rd = 1'b1;
            tare_sum_q = tare_sum_q + smp;
            tare_cnt_q = tare_cnt_q + 4'd1;
            r.ev = lcts_pkg::EV_TARE_SAMPLE;
            if (tare_cnt_q >= lcts_pkg::TARE_TOTAL) begin
              // integer divide truncates toward zero
              offset_q = 24'(tare_sum_q / int'(lcts_pkg::TARE_TOTAL));
              tared_q = 1'b1;
              phase_q = lcts_pkg::PH_WEIGH;
              r.ev = lcts_pkg::EV_TARE_DONE;
            end
          end
        end
        default: begin
          if (elapsed_q >= report_q) begin
            elapsed_q = '0;
            if (ready) begin
              r.rd = 1'b1;
              held_q = weigh_mg(smp);
              r.ev = lcts_pkg::EV_WEIGHT;
            end else begin
              r.ev = lcts_pkg::EV_LOST;
            end
          end
        end
      endcase
    end
    r.phase = phase_q;
    r.weight = held_q;
    r.progress = tare_cnt_q;
    r.offset = offset_q;
    r.tared = tared_q;
    r.conn = (phase_q == lcts_pkg::PH_WEIGH);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_total++;
      if (error_total <= 10)
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      scale_q    = lcts_pkg::SCALE_RST;
      zband_q    = lcts_pkg::ZERO_BAND_RST;
      probe_q    = lcts_pkg::PROBE_RST;
      settle_q   = lcts_pkg::SETTLE_RST;
      spacing_q  = lcts_pkg::SPACING_RST;
      report_q   = lcts_pkg::REPORT_RST;
      phase_q    = lcts_pkg::PH_PROBE;
      elapsed_q  = '0;
      tare_sum_q = 0;
      tare_cnt_q = '0;
      offset_q   = '0;
      tared_q    = 1'b0;
      held_q     = '0;
      pending_readings.delete();
    end else begin
      // register write lands on the access cycle
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          lcts_pkg::REG_SCALE:     scale_q   = cfg_pwdata[23:0];
          lcts_pkg::REG_ZERO_BAND: zband_q   = cfg_pwdata[15:0];
          lcts_pkg::REG_PROBE:     probe_q   = cfg_pwdata[15:0];
          lcts_pkg::REG_SETTLE:    settle_q  = cfg_pwdata[15:0];
          lcts_pkg::REG_SPACING:   spacing_q = cfg_pwdata[15:0];
          lcts_pkg::REG_REPORT:    report_q  = cfg_pwdata[15:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready)
        pending_readings.push_back(step_sequencer(in_tuser[0], in_tdata[0], in_tdata[24:1]));

      // compare accepted result word with oldest prediction
      if (out_tvalid && out_tready) begin
        if (pending_readings.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t result word with no prediction: tuser 0x%0h tdata 0x%0h",
                     $realtime, out_tuser, out_tdata);
        end else begin
          want = pending_readings.pop_front();
          check_field("phase",         32'(want.phase),    32'(out_tdata[1:0]));
          check_field("event_res",     32'(want.ev),       32'(out_tuser));
          check_field("sample_read",   32'(want.rd),       32'(out_tdata[2]));
          check_field("weight_mg",     want.weight,        out_tdata[34:3]);
          check_field("tare_progress", 32'(want.progress), 32'(out_tdata[38:35]));
          check_field("offset_now",    32'(want.offset),   32'(out_tdata[62:39]));
          check_field("tared",         32'(want.tared),    32'(out_tdata[63]));
          check_field("connected",     32'(want.conn),     32'(out_tdata[64]));
          check_field("pad",           32'd0,              32'(out_tdata[71:65]));
        end
      end
    end
    pending <= pending_readings.size();
  end

endmodule

// File: dv/tb_load_cell_tare_weigh_sequencer_core.sv
`timescale 1ns / 100ps
// Testbench top for the load cell sequencer: clock, reset, stimulus, register setup and verdict.
module tb_load_cell_tare_weigh_sequencer_core;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [0] sensor_ready, [24:1] sample_raw, [31:25] zero
  logic [0:0]  in_tuser = '0;   // [0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [1:0] phase, [2] sample_read, [34:3] weight_mg,
                                // [38:35] tare_progress, [62:39] offset_now,
                                // [63] tared, [64] connected, [71:65] zero
  logic [2:0]  out_tuser;       // [2:0] event_res
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit calm = 1'b0;          // no stalls on the result side
  bit sender_gaps = 1'b1;   // random gaps between input words
  bit hold_req = 1'b0;      // one long result-side stall
  int error_total;
  int pending;

  load_cell_tare_weigh_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  lcts_reading_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .error_total(error_total),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random ready/stall bursts, plus one long counted hold
  initial begin : result_sink
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (64) @(negedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
    end
  end

  // offer one word, wait for it to be taken; called and returns at a falling edge
  task automatic put_word(input logic cmd, input logic rdy, input logic [23:0] smp);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, smp, rdy};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop sending until every predicted word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [23:0] scale, input logic [15:0] zband,
                              input logic [15:0] probe, input logic [15:0] settle,
                              input logic [15:0] spacing, input logic [15:0] report);
    write_reg(lcts_pkg::REG_SCALE,     32'(scale));
    write_reg(lcts_pkg::REG_ZERO_BAND, 32'(zband));
    write_reg(lcts_pkg::REG_PROBE,     32'(probe));
    write_reg(lcts_pkg::REG_SETTLE,    32'(settle));
    write_reg(lcts_pkg::REG_SPACING,   32'(spacing));
    write_reg(lcts_pkg::REG_REPORT,    32'(report));
  endtask

  // mostly readings scattered around a load level, some wild values and rail hits
  function automatic logic [23:0] pick_sample(input logic [23:0] base);
    case ($urandom_range(0, 9))
      0:       return 24'($urandom());
      1:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return base + 24'($urandom_range(0, 4000)) - 24'd2000;
    endcase
  endfunction

  initial begin : stimulus
    logic [23:0] base;
    logic [23:0] scale_v;
    logic [15:0] zband_v, probe_v, settle_v;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: probing, retry interval far off
    repeat (3) put_word(lcts_pkg::CMD_TICK, 1'b0, 24'($urandom()));
    drain_results();

    // directed: fastest intervals, full-scale gain, no dead band
    program_regs(24'hFFFFFF, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    put_word(lcts_pkg::CMD_TICK, 1'b0, 24'h000000);   // not found
    put_word(lcts_pkg::CMD_TICK, 1'b0, 24'hFFFFFF);   // not found again
    put_word(lcts_pkg::CMD_TICK, 1'b1, 24'h7FFFFF);   // found
    put_word(lcts_pkg::CMD_TICK, 1'b0, 24'h000001);   // zero settle time, into taring
    put_word(lcts_pkg::CMD_TICK, 1'b0, 24'h800000);   // taring, converter busy
    for (int k = 0; k < 4; k++) put_word(lcts_pkg::CMD_TICK, 1'b1, 24'($urandom()));
    put_word(lcts_pkg::CMD_RETARE, 1'b1, 24'h7FFFFF); // re-tare in mid tare
    // rails alternating: sum is -5, offset truncates to 0
    for (int k = 0; k < 10; k++)
      put_word(lcts_pkg::CMD_TICK, 1'b1, k[0] ? 24'h800000 : 24'h7FFFFF);
    put_word(lcts_pkg::CMD_TICK, 1'b1, 24'h7FFFFF);   // top of the range
    put_word(lcts_pkg::CMD_TICK, 1'b1, 24'h800000);   // bottom of the range
    put_word(lcts_pkg::CMD_TICK, 1'b0, 24'h123456);   // lost
    put_word(lcts_pkg::CMD_TICK, 1'b1, 24'h000000);   // zero weight
    put_word(lcts_pkg::CMD_RETARE, 1'b0, 24'h000000); // re-tare while weighing

    // random phases with changing register settings
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        1:       begin scale_v = 24'd0;      zband_v = 16'hFFFF; end
        2:       begin scale_v = 24'hFFFFFF; zband_v = 16'd0;    end
        default: begin
          scale_v = $urandom_range(0, 1) ? 24'($urandom_range(1, 300000)) : 24'($urandom());
          zband_v = 16'($urandom_range(0, 3000));
        end
      endcase
      probe_v  = (p == 3) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      settle_v = (p == 3) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      program_regs(scale_v, zband_v, probe_v, settle_v,
                   16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)));
      base = 24'($urandom());
      calm = (p == 6);
      sender_gaps = (p != 6);
      if (p == 3) hold_req = 1'b1;
      if ($urandom_range(0, 1)) put_word(lcts_pkg::CMD_RETARE, 1'b0, base);
      for (int i = 0; i < 150; i++) begin
        if (p == 5 && i == 75) drain_results();
        put_word(($urandom_range(0, 99) < 2) ? lcts_pkg::CMD_RETARE : lcts_pkg::CMD_TICK,
                 $urandom_range(0, 99) < 80, pick_sample(base));
      end
    end

    // long spacing: a run of idle ticks before the tare sample is taken
    drain_results();
    program_regs(24'd65536, 16'd500, 16'd1, 16'd1, 16'd140, 16'hFFFF);
    calm = 1'b1;
    sender_gaps = 1'b0;
    put_word(lcts_pkg::CMD_RETARE, 1'b0, base);
    repeat (150) put_word(lcts_pkg::CMD_TICK, 1'b0, pick_sample(base));
    put_word(lcts_pkg::CMD_TICK, 1'b1, pick_sample(base));
    put_word(lcts_pkg::CMD_TICK, 1'b1, pick_sample(base));

    // closing stretch with no idling on either side
    drain_results();
    program_regs(24'($urandom_range(1, 300000)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 2)), 16'($urandom_range(1, 3)));
    base = 24'($urandom());
    put_word(lcts_pkg::CMD_RETARE, 1'b0, base);
    for (int i = 0; i < 200; i++)
      put_word(($urandom_range(0, 99) < 2) ? lcts_pkg::CMD_RETARE : lcts_pkg::CMD_TICK,
               $urandom_range(0, 99) < 85, pick_sample(base));

    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
    if (error_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: load_cell_tare_weigh_sequencer_core.f
design/lcts_pkg.sv
design/load_cell_tare_weigh_sequencer_core.sv
dv/lcts_reading_checker.sv
dv/tb_load_cell_tare_weigh_sequencer_core.sv
